// File: rtl/cfp_pkg.sv
`default_nettype none

package cfp_pkg;

  // Widths of the item fields and of the parser state.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 16;
  localparam int unsigned CountW = 7;
  localparam int unsigned StatW  = 3;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  // A timeout check is made on every CHECK_INTERVAL-th byte since the last parser restart.
  localparam int unsigned CHECK_INTERVAL = 100;
  localparam logic [CountW-1:0] CheckIntervalC = CountW'(CHECK_INTERVAL);
  // Byte counter value after a restart caused by the byte that follows a complete frame.
  localparam logic [CountW-1:0] RestartCountC = (CHECK_INTERVAL <= 1) ? '0 : CountW'(1);

  localparam logic [LenW-1:0] LenMaxC = '1;

  // Register reset values.
  localparam logic [ByteW-1:0] FirstHeaderRst    = 8'd170;
  localparam logic [ByteW-1:0] SecondHeaderRst   = 8'd85;
  localparam logic [ByteW-1:0] FirstTailRst      = 8'd13;
  localparam logic [ByteW-1:0] SecondTailRst     = 8'd10;
  localparam logic [ByteW-1:0] LowestCommandRst  = 8'd1;
  localparam logic [ByteW-1:0] HighestCommandRst = 8'd8;
  localparam logic [LenW-1:0]  LongestPayloadRst = 16'd1024;
  localparam logic [LenW-1:0]  TimeoutTicksRst   = 16'd1000;

  typedef enum logic [2:0] {
    REG_FIRST_HEADER    = 3'd0,
    REG_SECOND_HEADER   = 3'd1,
    REG_FIRST_TAIL      = 3'd2,
    REG_SECOND_TAIL     = 3'd3,
    REG_LOWEST_COMMAND  = 3'd4,
    REG_HIGHEST_COMMAND = 3'd5,
    REG_LONGEST_PAYLOAD = 3'd6,
    REG_TIMEOUT_TICKS   = 3'd7
  } reg_idx_e;

  typedef enum logic [3:0] {
    PH_HEAD1 = 4'd0,
    PH_HEAD2 = 4'd1,
    PH_CMD   = 4'd2,
    PH_LENH  = 4'd3,
    PH_LENL  = 4'd4,
    PH_DATA  = 4'd5,
    PH_TAIL1 = 4'd6,
    PH_TAIL2 = 4'd7,
    PH_DONE  = 4'd8
  } phase_e;

  typedef enum logic [StatW-1:0] {
    ST_MORE      = 3'd0,
    ST_COMPLETE  = 3'd1,
    ST_FRAME_ERR = 3'd2,
    ST_BAD_CMD   = 3'd3,
    ST_TOO_LONG  = 3'd4
  } status_e;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef struct packed {
    logic [ByteW-1:0] first_header;
    logic [ByteW-1:0] second_header;
    logic [ByteW-1:0] first_tail;
    logic [ByteW-1:0] second_tail;
    logic [ByteW-1:0] lowest_command;
    logic [ByteW-1:0] highest_command;
    logic [LenW-1:0]  longest_payload;
    logic [LenW-1:0]  timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic             op;
    logic [ByteW-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [ByteW-1:0] command_code;
    logic [LenW-1:0]  frame_length;
    logic             payload_valid;
    logic [ByteW-1:0] payload_value;
    logic [LenW-1:0]  payload_index;
    logic [LenW-1:0]  errors_seen;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/cfp_regs.sv
`default_nettype none

module cfp_regs
  import cfp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output cfg_t                  cfg_o
);

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  reg_idx_e reg_idx;
  logic     wr_en;

  // Registers sit on word addresses; the low two address bits are ignored.
  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en   = psel & penable & pwrite;

  // Write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_FIRST_HEADER:    cfg_d.first_header    = pwdata[ByteW-1:0];
        REG_SECOND_HEADER:   cfg_d.second_header   = pwdata[ByteW-1:0];
        REG_FIRST_TAIL:      cfg_d.first_tail      = pwdata[ByteW-1:0];
        REG_SECOND_TAIL:     cfg_d.second_tail     = pwdata[ByteW-1:0];
        REG_LOWEST_COMMAND:  cfg_d.lowest_command  = pwdata[ByteW-1:0];
        REG_HIGHEST_COMMAND: cfg_d.highest_command = pwdata[ByteW-1:0];
        REG_LONGEST_PAYLOAD: cfg_d.longest_payload = pwdata[LenW-1:0];
        REG_TIMEOUT_TICKS:   cfg_d.timeout_ticks   = pwdata[LenW-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_header    <= FirstHeaderRst;
      cfg_q.second_header   <= SecondHeaderRst;
      cfg_q.first_tail      <= FirstTailRst;
      cfg_q.second_tail     <= SecondTailRst;
      cfg_q.lowest_command  <= LowestCommandRst;
      cfg_q.highest_command <= HighestCommandRst;
      cfg_q.longest_payload <= LongestPayloadRst;
      cfg_q.timeout_ticks   <= TimeoutTicksRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read decode.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_FIRST_HEADER:    prdata = DataW'(cfg_q.first_header);
      REG_SECOND_HEADER:   prdata = DataW'(cfg_q.second_header);
      REG_FIRST_TAIL:      prdata = DataW'(cfg_q.first_tail);
      REG_SECOND_TAIL:     prdata = DataW'(cfg_q.second_tail);
      REG_LOWEST_COMMAND:  prdata = DataW'(cfg_q.lowest_command);
      REG_HIGHEST_COMMAND: prdata = DataW'(cfg_q.highest_command);
      REG_LONGEST_PAYLOAD: prdata = DataW'(cfg_q.longest_payload);
      REG_TIMEOUT_TICKS:   prdata = DataW'(cfg_q.timeout_ticks);
      default:             prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/cfp_core.sv
`default_nettype none

module cfp_core
  import cfp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_fire_i,
  input  in_item_t      item_i,
  input  cfg_t          cfg_i,
  output out_item_t     result_o
);

  phase_e              phase_q, phase_d;
  logic [ByteW-1:0]    cmd_q, cmd_d;
  logic [LenW-1:0]     len_q, len_d;
  logic [LenW-1:0]     cnt_q, cnt_d;
  logic [CountW-1:0]   bsc_q, bsc_d;
  logic [LenW-1:0]     ticks_q, ticks_d;
  logic [LenW-1:0]     err_q, err_d;

  logic                is_byte;
  logic [ByteW-1:0]    b;
  logic [CountW-1:0]   bsc_inc;
  logic                chk;
  logic                timeout_hit;
  logic                parse_en;
  logic                done_restart;
  phase_e              eff_phase;
  logic [LenW-1:0]     len_full;
  logic [LenW-1:0]     cnt_inc;
  logic                parse_fail;
  status_e             parse_code;
  phase_e              ph_next;
  logic                complete;
  logic                take_payload;
  logic                fail;
  status_e             fail_code;

  assign is_byte      = (op_e'(item_i.op) == OP_BYTE);
  assign b            = item_i.data_byte;
  assign bsc_inc      = bsc_q + CountW'(1);
  assign chk          = (bsc_inc >= CheckIntervalC);
  assign timeout_hit  = is_byte && chk && (phase_q != PH_HEAD1) &&
                        (ticks_q > cfg_i.timeout_ticks);
  assign parse_en     = is_byte && !timeout_hit;
  assign done_restart = (phase_q == PH_DONE);
  // The byte after a complete frame is parsed as a fresh first header byte.
  assign eff_phase    = done_restart ? PH_HEAD1 : phase_q;
  assign len_full     = len_q | LenW'(b);
  assign cnt_inc      = cnt_q + LenW'(1);

  // Per-phase decode of the received byte.
  always_comb begin
    parse_fail   = 1'b0;
    parse_code   = ST_FRAME_ERR;
    ph_next      = eff_phase;
    complete     = 1'b0;
    take_payload = 1'b0;
    unique case (eff_phase)
      PH_HEAD2: begin
        if (b == cfg_i.second_header) begin
          ph_next = PH_CMD;
        end else begin
          parse_fail = 1'b1;
        end
      end
      PH_CMD: begin
        if (b >= cfg_i.lowest_command && b <= cfg_i.highest_command) begin
          ph_next = PH_LENH;
        end else begin
          parse_fail = 1'b1;
          parse_code = ST_BAD_CMD;
        end
      end
      PH_LENH: ph_next = PH_LENL;
      PH_LENL: begin
        if (len_full > cfg_i.longest_payload) begin
          parse_fail = 1'b1;
          parse_code = ST_TOO_LONG;
        end else if (len_full == '0) begin
          ph_next = PH_TAIL1;
        end else begin
          ph_next = PH_DATA;
        end
      end
      PH_DATA: begin
        take_payload = 1'b1;
        ph_next      = (cnt_inc >= len_q) ? PH_TAIL1 : PH_DATA;
      end
      PH_TAIL1: begin
        if (b == cfg_i.first_tail) begin
          ph_next = PH_TAIL2;
        end else begin
          parse_fail = 1'b1;
        end
      end
      PH_TAIL2: begin
        if (b == cfg_i.second_tail) begin
          ph_next  = PH_DONE;
          complete = 1'b1;
        end else begin
          parse_fail = 1'b1;
        end
      end
      default: begin
        // Waiting for the first header; unused codes behave the same way.
        ph_next = (b == cfg_i.first_header) ? PH_HEAD2 : PH_HEAD1;
      end
    endcase
  end

  assign fail      = timeout_hit || (parse_en && parse_fail);
  assign fail_code = timeout_hit ? ST_FRAME_ERR : parse_code;

  // Next state of the parser.
  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    bsc_d   = bsc_q;
    ticks_d = ticks_q;
    err_d   = err_q;
    if (in_fire_i) begin
      if (!is_byte) begin
        if (ticks_q != LenMaxC) begin
          ticks_d = ticks_q + LenW'(1);
        end
      end else if (fail) begin
        // Any error restarts the parser and bumps the saturating error count.
        phase_d = PH_HEAD1;
        cmd_d   = '0;
        len_d   = '0;
        cnt_d   = '0;
        bsc_d   = '0;
        ticks_d = '0;
        if (err_q != LenMaxC) begin
          err_d = err_q + LenW'(1);
        end
      end else begin
        bsc_d = chk ? '0 : bsc_inc;
        if (done_restart) begin
          cmd_d   = '0;
          len_d   = '0;
          cnt_d   = '0;
          ticks_d = '0;
          bsc_d   = RestartCountC;
        end
        phase_d = ph_next;
        case (eff_phase)
          PH_CMD:  cmd_d = b;
          PH_LENH: len_d = {b, 8'h00};
          PH_LENL: begin
            len_d = len_full;
            cnt_d = '0;
          end
          PH_DATA: cnt_d = cnt_inc;
          default: begin
            if (eff_phase == PH_HEAD1 && ph_next == PH_HEAD2) begin
              ticks_d = '0;
            end
          end
        endcase
      end
    end
  end

  // Result of the accepted item.
  always_comb begin
    result_o             = '0;
    result_o.errors_seen = err_d;
    if (fail) begin
      result_o.status = fail_code;
    end else if (parse_en && complete) begin
      result_o.status       = ST_COMPLETE;
      result_o.command_code = cmd_q;
      result_o.frame_length = len_q;
    end else begin
      result_o.status = ST_MORE;
    end
    if (parse_en && take_payload) begin
      result_o.payload_valid = 1'b1;
      result_o.payload_value = b;
      result_o.payload_index = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD1;
      cmd_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      bsc_q   <= '0;
      ticks_q <= '0;
      err_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      bsc_q   <= bsc_d;
      ticks_q <= ticks_d;
      err_q   <= err_d;
    end
  end

`ifndef NO_ASSERTIONS
  // The error count never goes down.
  a_err_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> err_q >= $past(err_q))
    else $error("error count decreased");

  // The payload count never runs past the announced length.
  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= len_q)
    else $error("payload count beyond frame length");

  // Payload bytes come out only while the parser is in the payload phase.
  a_payload_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i && result_o.payload_valid |-> phase_q == PH_DATA)
    else $error("payload byte outside payload phase");

  // A complete frame is reported only on the second tail byte.
  a_complete_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i && result_o.status == ST_COMPLETE |=> phase_q == PH_DONE)
    else $error("frame complete without entering done phase");
`endif

endmodule

`default_nettype wire

// File: rtl/cfp_out_buf.sv
`default_nettype none

module cfp_out_buf
  import cfp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  out_item_t  push_data_i,
  output logic       ready_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output out_item_t  out_data_o
);

  logic      main_valid_q, main_valid_d;
  out_item_t main_data_q, main_data_d;
  logic      skid_valid_q, skid_valid_d;
  out_item_t skid_data_q, skid_data_d;
  logic      main_free;

  // The output register drains this cycle or is empty.
  assign main_free = !main_valid_q || out_ready_i;
  assign ready_o   = !skid_valid_q;

  // Output register with a skid entry behind it.
  always_comb begin
    main_valid_d = main_valid_q;
    main_data_d  = main_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (main_free) begin
      if (skid_valid_q) begin
        main_valid_d = 1'b1;
        main_data_d  = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        main_valid_d = push_i;
        if (push_i) begin
          main_data_d = push_data_i;
        end
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_data_q <= main_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_data_q;

`ifndef NO_ASSERTIONS
  // The skid entry is only ever used behind a full output register.
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry holds data while output register is empty");

  // No transaction is taken while both entries are full.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !main_free |-> !push_i)
    else $error("push into full output buffer");
`endif

endmodule

`default_nettype wire

// File: rtl/command_frame_parser_unit.sv
// Command frame parser.
// Input channel (in_valid_i/in_ready_o/in_data_i): each transaction is either a
// received byte or one time tick. Bytes are parsed as frames of two header bytes,
// a command byte, a big-endian 16-bit length, the payload and two tail bytes.
// Output channel (out_valid_o/out_ready_i/out_data_o): exactly one transaction
// per input transaction, in order, with the parse status, the frame command and
// length on completion, each payload byte with its index, and the error count.
// Each accepted item's result is registered in the output register or skid entry.
// Throughput is one item per cycle while in_ready_o is high; the parse step is a
// single compare and update between the parser state and output registers.
// A two-entry output buffer (output register plus skid entry) keeps in_ready_o
// high while one result waits; when the receiver stalls long enough to fill both
// entries, in_ready_o drops until a result is taken. Reset loads the register
// defaults, puts the parser in the wait-for-header state, clears the error count.
// The user must write registers over the APB port only while idle (not enforced).
`default_nettype none

module command_frame_parser_unit
  import cfp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_item_t             out_data_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready
);

  cfg_t      cfg;
  out_item_t result;
  logic      in_fire;

  assign pready  = 1'b1;
  assign in_fire = in_valid_i && in_ready_o;

  cfp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  cfp_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .item_i    (in_data_i),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  cfp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire),
    .push_data_i (result),
    .ready_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
